@@ hw/rtl/lr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants of the line rasterizer
// Request, pixel and internal command layouts, plus the request type codes.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int COORD_BITS    = 10;
  localparam int REM_BITS      = COORD_BITS + 1;
  localparam int COLOR_BITS    = 4;
  localparam int QUEUE_DEPTH_D = 2;

  // request type codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] line_color;
  } req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;
  } pixel_t;

  // classified request as it travels from front to back
  typedef struct packed {
    logic                  is_start;
    logic                  x_is_major;
    logic                  minor_step_up;
    logic [COORD_BITS-1:0] major_position;
    logic [COORD_BITS-1:0] major_limit;
    logic [COORD_BITS-1:0] minor_position;
    logic [COORD_BITS-1:0] major_span;
    logic [COORD_BITS-1:0] minor_span;
    logic [COLOR_BITS-1:0] color;
  } cmd_t;

endpackage

@@ hw/rtl/lr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_front: request classifier
// Turns a start request into the line setup (axis, direction, spans) and
// marks step requests, ready to be queued for the stepper.
// ----------------------------------------------------------------------------
module lr_front
  import lr_pkg::*;
(
  input  req_t req,
  output cmd_t cmd
);

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  x_major;
  logic [COORD_BITS-1:0] maj_s;
  logic [COORD_BITS-1:0] maj_e;
  logic [COORD_BITS-1:0] min_s;
  logic [COORD_BITS-1:0] min_e;
  logic                  swap;
  logic [COORD_BITS-1:0] first_min;
  logic [COORD_BITS-1:0] other_min;
  logic [COORD_BITS-1:0] pos;
  logic [COORD_BITS-1:0] lim;

  always_comb begin
    dx      = abs_diff(req.x_start, req.x_end);
    dy      = abs_diff(req.y_start, req.y_end);
    x_major = (dx >= dy);
    maj_s   = x_major ? req.x_start : req.y_start;
    maj_e   = x_major ? req.x_end   : req.y_end;
    min_s   = x_major ? req.y_start : req.x_start;
    min_e   = x_major ? req.y_end   : req.x_end;
    // walk from the smaller major coordinate
    swap      = (maj_s > maj_e);
    pos       = swap ? maj_e : maj_s;
    lim       = swap ? maj_s : maj_e;
    first_min = swap ? min_e : min_s;
    other_min = swap ? min_s : min_e;

    cmd.is_start       = (req.req_type == REQ_START);
    cmd.x_is_major     = x_major;
    cmd.minor_step_up  = (other_min >= first_min);
    cmd.major_position = pos;
    cmd.major_limit    = lim;
    cmd.minor_position = first_min;
    cmd.major_span     = lim - pos;
    cmd.minor_span     = abs_diff(first_min, other_min);
    cmd.color          = req.line_color;
  end

endmodule

@@ hw/rtl/lr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_queue: command queue between front and back
// Small show-ahead fifo so the classifier and the stepper stall separately.
// ----------------------------------------------------------------------------
module lr_queue
  import lr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_D
)(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output cmd_t rdata,
  output logic empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  cmd_t                entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

  a_ptrs_match_when_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

@@ hw/rtl/lr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_back: line stepper with result register
// Holds the active line, emits one pixel per step command on an active line
// and advances the minor coordinate with an exact integer remainder.
// ----------------------------------------------------------------------------
module lr_back
  import lr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   cmd_valid,
  input  cmd_t   cmd,
  output logic   cmd_take,
  output pixel_t result,
  output logic   empty,
  input  logic   pop
);

  logic                  line_active;
  logic                  x_is_major;
  logic [COORD_BITS-1:0] major_position;
  logic [COORD_BITS-1:0] major_limit;
  logic [COORD_BITS-1:0] minor_position;
  logic                  minor_step_up;
  logic [COORD_BITS-1:0] major_span;
  logic [COORD_BITS-1:0] minor_span;
  logic [REM_BITS-1:0]   remainder_acc;
  logic [COLOR_BITS-1:0] held_color;
  logic                  out_valid;

  logic                  last;
  logic                  emit;
  logic                  advance;
  logic [REM_BITS:0]     up_sum;
  logic [REM_BITS:0]     up_wrap;
  logic                  up_carry;
  logic                  down_borrow;
  logic [REM_BITS-1:0]   remainder_next;
  logic [COORD_BITS-1:0] minor_next;

  assign cmd_take = cmd_valid && (!out_valid || pop);
  assign last     = (major_position == major_limit);
  assign emit     = cmd_take && !cmd.is_start && line_active;
  assign advance  = emit && !last;
  assign empty    = !out_valid;

  always_comb begin
    up_sum      = {1'b0, remainder_acc} + {2'b00, minor_span};
    up_carry    = (up_sum >= {2'b00, major_span});
    up_wrap     = up_sum - {2'b00, major_span};
    down_borrow = (remainder_acc < {1'b0, minor_span});
    if (minor_step_up) begin
      remainder_next = up_carry ? up_wrap[REM_BITS-1:0] : up_sum[REM_BITS-1:0];
      minor_next     = up_carry ? minor_position + 1'b1 : minor_position;
    end else if (down_borrow) begin
      remainder_next = remainder_acc + {1'b0, major_span} - {1'b0, minor_span};
      minor_next     = minor_position - 1'b1;
    end else begin
      remainder_next = remainder_acc - {1'b0, minor_span};
      minor_next     = minor_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd_take) begin
        out_valid <= emit;
        if (cmd.is_start) begin
          line_active <= 1'b1;
        end else if (emit && last) begin
          line_active <= 1'b0;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.is_start) begin
      x_is_major     <= cmd.x_is_major;
      minor_step_up  <= cmd.minor_step_up;
      major_position <= cmd.major_position;
      major_limit    <= cmd.major_limit;
      minor_position <= cmd.minor_position;
      major_span     <= cmd.major_span;
      minor_span     <= cmd.minor_span;
      remainder_acc  <= '0;
      held_color     <= cmd.color;
    end else if (advance) begin
      major_position <= major_position + 1'b1;
      minor_position <= minor_next;
      remainder_acc  <= remainder_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.pixel_x     <= x_is_major ? major_position : minor_position;
      result.pixel_y     <= x_is_major ? minor_position : major_position;
      result.pixel_color <= held_color;
      result.last_pixel  <= last;
    end
  end

  a_start_arms_line: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd.is_start) |=> line_active)
    else $error("start request did not arm the line");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (emit && last) |=> !line_active && out_valid && result.last_pixel)
    else $error("final pixel did not close the line");

  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && !cmd.is_start && !line_active) |=> !out_valid)
    else $error("step without an active line produced a pixel");

endmodule

@@ hw/rtl/line_rasterizer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_unit: incremental line rasterizer
// Requests come in through a queue-style port: push with a request while
// full is low. A start request latches two endpoints and a color and
// produces no pixel; each step request produces the next pixel of the line,
// walked along the major axis from the smaller major coordinate, with the
// final pixel flagged by last_pixel. A step with no active line produces
// nothing. Pixels leave through a queue-style port: the oldest pixel sits on
// result while empty is low and is taken with pop.
// A step request goes into the command queue, then its pixel is registered in
// result. Throughput: one request per cycle while result is popped, set by
// the stepper, which advances one pixel per cycle with an add and a compare.
// A command queue of QUEUE_DEPTH entries sits between classifier and
// stepper; when pop stays low the result register holds, the queue fills
// and full rises. Reset (synchronous) empties the queue, drops any active
// line and empties the result register.
// ----------------------------------------------------------------------------
module line_rasterizer_unit
  import lr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
)(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  req_t   item,
  output logic   full,
  input  logic   pop,
  output pixel_t result,
  output logic   empty
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_empty;
  logic cmd_take;
  logic queue_push;

  assign queue_push = push && !full;

  lr_front u_front (
    .req (item),
    .cmd (front_cmd)
  );

  lr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (queue_push),
    .wdata (front_cmd),
    .full  (full),
    .pop   (cmd_take),
    .rdata (queue_cmd),
    .empty (queue_empty)
  );

  lr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!queue_empty),
    .cmd       (queue_cmd),
    .cmd_take  (cmd_take),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
